[hdl/access_range_conflict_tracker_defines.svh]
// Assertion macros for the access range conflict tracker.
// Each macro expects signals named clk and rst in the calling scope.
`ifndef ACCESS_RANGE_CONFLICT_TRACKER_DEFINES_SVH
`define ACCESS_RANGE_CONFLICT_TRACKER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked outside reset.
`define ARCT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("arct: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ARCT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("arct: next-cycle check failed");

`else

`define ARCT_ASSERT_IMP(lbl, ante, cons)
`define ARCT_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

[hdl/arct_pkg.sv]
package arct_pkg;

  localparam int NUM_SLOTS   = 8;
  localparam int OFFSET_BITS = 16;
  localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  typedef enum logic {
    OP_BEGIN   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_SUMMARY = 2'd0,
    KIND_RAW     = 2'd1,
    KIND_WAR     = 2'd2,
    KIND_WAW     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // One window as held in the slot memory
  typedef struct packed {
    logic [7:0]             owner;
    logic                   is_write;
    logic [OFFSET_BITS-1:0] low;
    logic [OFFSET_BITS-1:0] high;
  } slot_entry_t;

  // Captured request; end_ext carries one extra bit so it never wraps
  typedef struct packed {
    op_t                    op;
    logic [7:0]             requester_id;
    logic                   is_write;
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS:0]   end_ext;
  } req_t;

  // Verdict of the window checker for one slot
  typedef struct packed {
    logic  report;
    kind_t kind;
    logic  release_hit;
  } check_t;

  // One result beat
  typedef struct packed {
    kind_t      kind;
    logic [2:0] conflict_slot;
    logic [7:0] other_owner;
    logic       status;
    logic       slot_granted;
    logic       last;
  } res_t;

endpackage

[hdl/arct_item_if.sv]
interface arct_item_if import arct_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   op;
  logic [7:0]             requester_id;
  logic                   is_write;
  logic [OFFSET_BITS-1:0] start_offset;
  logic [OFFSET_BITS-1:0] length;
  logic [15:0]            buffer_size;

  modport source (output valid, op, requester_id, is_write, start_offset, length,
                  buffer_size, input ready);
  modport sink (input valid, op, requester_id, is_write, start_offset, length,
                buffer_size, output ready);
endinterface

[hdl/arct_result_if.sv]
interface arct_result_if import arct_pkg::*; ();
  logic       valid;
  logic       ready;
  kind_t      kind;
  logic [2:0] conflict_slot;
  logic [7:0] other_owner;
  logic       status;
  logic       slot_granted;
  logic       last;

  modport source (output valid, kind, conflict_slot, other_owner, status, slot_granted,
                  last, input ready);
  modport sink (input valid, kind, conflict_slot, other_owner, status, slot_granted,
                last, output ready);
endinterface

[hdl/arct_slot_ram.sv]
module arct_slot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/arct_window_check.sv]
module arct_window_check import arct_pkg::*; (
  input  slot_entry_t entry,
  input  logic        entry_valid,
  input  req_t        req,
  output check_t      chk
);

  logic other;
  logic overlap;

  // Occupied slot held by someone else
  assign other = entry_valid && (entry.owner != req.requester_id);

  // Inclusive range intersection, end carried one bit wider
  assign overlap = !(({1'b0, req.start} > {1'b0, entry.high}) ||
                     (req.end_ext < {1'b0, entry.low}));

  // Classify the hazard; two reads never conflict
  always_comb begin
    chk = '0;
    chk.kind = KIND_SUMMARY;
    chk.report = (req.op == OP_BEGIN) && other && overlap &&
                 (entry.is_write || req.is_write);
    if (entry.is_write) begin
      chk.kind = req.is_write ? KIND_WAW : KIND_RAW;
    end else begin
      chk.kind = KIND_WAR;
    end
    chk.release_hit = (req.op == OP_RELEASE) && entry_valid &&
                      (req.requester_id != 8'd0) &&
                      (entry.owner == req.requester_id);
  end

endmodule

[hdl/access_range_conflict_tracker.sv]
// Access range conflict tracker.
// Channels: item (sink) takes begin-access and release requests; result (source)
// gives conflict reports followed by one summary beat with last set. Both use a
// valid/ready handshake; a beat moves when valid and ready are both high.
// Windows live in an NUM_SLOTS-entry memory with a registered read port, plus a
// flip-flop valid bit per slot.
// Timing: a begin or release item walks the table one slot per cycle while
// no report is held back by a full output register; a begin that fails on zero
// length or buffer size skips the walk and goes straight to the summary.
// The next item is accepted in the cycle after the summary is loaded, so no new
// item is taken while an earlier one walks the table or waits to be summarized.
// Results: each report is loaded from the registered slot read into the output
// register, letting the walk go on while an earlier beat waits to be taken.
// Stall: while result.ready is low and the output register is full, the walk
// holds on any slot with a report to place and the summary waits; item.ready
// stays low until the summary is loaded.
// Reset: clears all valid bits at once, so the table is empty in the first
// cycle after reset; no clearing pass is needed.
`include "access_range_conflict_tracker_defines.svh"

module access_range_conflict_tracker import arct_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  arct_item_if.sink            item,
  arct_result_if.source        result
);

  localparam int ENTRY_W = $bits(slot_entry_t);

  state_t              state, state_next;
  req_t                req, req_next;
  logic                fail, fail_next;
  logic [SLOT_W-1:0]   idx, idx_next;
  logic                free_found, free_found_next;
  logic [SLOT_W-1:0]   free_idx, free_idx_next;
  logic [NUM_SLOTS-1:0] slot_valid, slot_valid_next;

  logic                out_valid, out_valid_next;
  res_t                out_data, out_data_next;
  logic                out_load;
  logic                out_free;

  logic                ram_re;
  logic [SLOT_W-1:0]   ram_raddr;
  logic                ram_we;
  logic [ENTRY_W-1:0]  ram_rdata;
  slot_entry_t         claim;
  slot_entry_t         entry;
  check_t              chk;
  logic                granted;
  logic [SLOT_W+2:0]   slot_wide;
  logic [OFFSET_BITS:0] end_in;

  arct_slot_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SLOTS),
    .AW    (SLOT_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata (claim),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Free slots read as empty windows
  assign entry = slot_valid[idx] ? slot_entry_t'(ram_rdata) : '0;

  arct_window_check u_check (
    .entry       (entry),
    .entry_valid (slot_valid[idx]),
    .req         (req),
    .chk         (chk)
  );

  // New window: saturate the high offset at the top of the offset space
  always_comb begin
    claim          = '0;
    claim.owner    = req.requester_id;
    claim.is_write = req.is_write;
    claim.low      = req.start;
    claim.high     = req.end_ext[OFFSET_BITS] ? '1 : req.end_ext[OFFSET_BITS-1:0];
  end

  assign end_in = {1'b0, item.start_offset} + {1'b0, item.length} -
                  (OFFSET_BITS + 1)'(1);
  assign slot_wide = {3'b000, idx};
  assign granted = !fail && (req.op == OP_BEGIN) && (req.requester_id != 8'd0) &&
                   free_found;
  assign out_free = !out_valid || result.ready;
  assign item.ready = (state == ST_IDLE);

  // Sequencer: capture, walk the table unless a begin fails, then summarize and claim
  always_comb begin
    state_next      = state;
    req_next        = req;
    fail_next       = fail;
    idx_next        = idx;
    free_found_next = free_found;
    free_idx_next   = free_idx;
    slot_valid_next = slot_valid;
    ram_re          = 1'b0;
    ram_raddr       = '0;
    ram_we          = 1'b0;
    out_load        = 1'b0;
    out_data_next   = '0;
    out_data_next.kind = KIND_SUMMARY;

    unique case (state)
      ST_IDLE: begin
        if (item.valid) begin
          req_next.op           = op_t'(item.op);
          req_next.requester_id = item.requester_id;
          req_next.is_write     = item.is_write;
          req_next.start        = item.start_offset;
          req_next.end_ext      = end_in;
          fail_next = (op_t'(item.op) == OP_BEGIN) &&
                      ((item.length == '0) || (item.buffer_size == 16'd0));
          idx_next        = '0;
          free_found_next = 1'b0;
          free_idx_next   = '0;
          if ((op_t'(item.op) == OP_BEGIN) &&
              ((item.length == '0) || (item.buffer_size == 16'd0))) begin
            state_next = ST_DONE;
          end else begin
            ram_re     = 1'b1;
            ram_raddr  = '0;
            state_next = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Hold on this slot while a report cannot be placed
        if (!chk.report || out_free) begin
          if (chk.report) begin
            out_load                    = 1'b1;
            out_data_next.kind          = chk.kind;
            out_data_next.conflict_slot = slot_wide[2:0];
            out_data_next.other_owner   = entry.owner;
          end
          if (chk.release_hit) begin
            slot_valid_next[idx] = 1'b0;
          end
          if (!slot_valid[idx] && !free_found) begin
            free_found_next = 1'b1;
            free_idx_next   = idx;
          end
          if (idx == LAST_SLOT) begin
            state_next = ST_DONE;
          end else begin
            idx_next   = idx + SLOT_W'(1);
            ram_re     = 1'b1;
            ram_raddr  = idx + SLOT_W'(1);
          end
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_load                   = 1'b1;
          out_data_next.status       = fail;
          out_data_next.slot_granted = granted;
          out_data_next.last         = 1'b1;
          if (granted) begin
            ram_we                    = 1'b1;
            slot_valid_next[free_idx] = 1'b1;
          end
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register: load a beat, drop it once taken
  always_comb begin
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (result.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      slot_valid <= slot_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk) begin
    req        <= req_next;
    fail       <= fail_next;
    idx        <= idx_next;
    free_found <= free_found_next;
    free_idx   <= free_idx_next;
    if (out_load) begin
      out_data <= out_data_next;
    end
  end

  assign result.valid         = out_valid;
  assign result.kind          = out_data.kind;
  assign result.conflict_slot = out_data.conflict_slot;
  assign result.other_owner   = out_data.other_owner;
  assign result.status        = out_data.status;
  assign result.slot_granted  = out_data.slot_granted;
  assign result.last          = out_data.last;

  `ARCT_ASSERT_NXT(a_busy_after_accept, item.valid && item.ready, !item.ready)
  `ARCT_ASSERT_NXT(a_claim_marks_valid, ram_we, slot_valid[$past(free_idx)])
  `ARCT_ASSERT_IMP(a_report_only_in_walk, out_load && (state != ST_SCAN), out_data_next.last)

endmodule

[test/testbench.sv]
module testbench import arct_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 400_000;
  localparam int RANDOM_ITEMS = 400;
  localparam int QUIET_ITEMS  = 60;

  typedef struct {
    op_t                    op;
    logic [7:0]             id;
    logic                   wr;
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS-1:0] len;
    logic [15:0]            bsz;
  } access_item_t;

  // Window table mirror and the result beats it predicts
  class window_tracker;
    logic [7:0]             owner [NUM_SLOTS];
    logic                   wr    [NUM_SLOTS];
    logic [OFFSET_BITS-1:0] lo    [NUM_SLOTS];
    logic [OFFSET_BITS-1:0] hi    [NUM_SLOTS];
    res_t                   pending_beats [$];
    int                     mismatches;

    function new();
      mismatches = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        owner[i] = '0;
        wr[i]    = 1'b0;
        lo[i]    = '0;
        hi[i]    = '0;
      end
    endfunction

    task report(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    function res_t beat(kind_t k, int slot, logic [7:0] own, logic st, logic g, logic l);
      res_t r;
      r.kind          = k;
      r.conflict_slot = 3'(slot);
      r.other_owner   = own;
      r.status        = st;
      r.slot_granted  = g;
      r.last          = l;
      return r;
    endfunction

    // Predict the beats of one accepted item and update the table
    function void note_item(access_item_t it);
      logic [OFFSET_BITS:0] last_byte;
      logic                 granted;
      granted = 1'b0;
      if (it.op == OP_RELEASE) begin
        if (it.id != 0) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (owner[i] == it.id) begin
              owner[i] = '0;
              wr[i]    = 1'b0;
              lo[i]    = '0;
              hi[i]    = '0;
            end
          end
        end
        pending_beats.push_back(beat(KIND_SUMMARY, 0, 8'd0, 1'b0, 1'b0, 1'b1));
        return;
      end
      if (it.len == 0 || it.bsz == 0) begin
        pending_beats.push_back(beat(KIND_SUMMARY, 0, 8'd0, 1'b1, 1'b0, 1'b1));
        return;
      end
      // end of the range with one extra bit so it never wraps
      last_byte = {1'b0, it.start} + {1'b0, it.len} - 1'b1;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (owner[i] == 0 || owner[i] == it.id) continue;
        if ({1'b0, it.start} > {1'b0, hi[i]} || last_byte < {1'b0, lo[i]}) continue;
        if (wr[i])
          pending_beats.push_back(beat(it.wr ? KIND_WAW : KIND_RAW, i, owner[i],
                                       1'b0, 1'b0, 1'b0));
        else if (it.wr)
          pending_beats.push_back(beat(KIND_WAR, i, owner[i], 1'b0, 1'b0, 1'b0));
      end
      // claim the first free slot, saturating the high offset
      if (it.id != 0) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (owner[i] == 0) begin
            owner[i] = it.id;
            wr[i]    = it.wr;
            lo[i]    = it.start;
            hi[i]    = last_byte[OFFSET_BITS] ? '1 : last_byte[OFFSET_BITS-1:0];
            granted  = 1'b1;
            break;
          end
        end
      end
      pending_beats.push_back(beat(KIND_SUMMARY, 0, 8'd0, 1'b0, granted, 1'b1));
    endfunction

    // Compare one accepted result beat with the oldest prediction
    task check_beat(res_t got);
      res_t want;
      if (pending_beats.size() == 0) begin
        report($sformatf("unexpected beat kind=%0d slot=%0d owner=%0d last=%0b",
                         got.kind, got.conflict_slot, got.other_owner, got.last));
        return;
      end
      want = pending_beats.pop_front();
      if (got.kind != want.kind)
        report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      if (got.conflict_slot != want.conflict_slot)
        report($sformatf("conflict_slot %0d, expected %0d", got.conflict_slot,
                         want.conflict_slot));
      if (got.other_owner != want.other_owner)
        report($sformatf("other_owner %0d, expected %0d", got.other_owner,
                         want.other_owner));
      if (got.status != want.status)
        report($sformatf("status %0b, expected %0b", got.status, want.status));
      if (got.slot_granted != want.slot_granted)
        report($sformatf("slot_granted %0b, expected %0b", got.slot_granted,
                         want.slot_granted));
      if (got.last != want.last)
        report($sformatf("last %0b, expected %0b", got.last, want.last));
    endtask
  endclass

  logic clk;
  logic rst;
  int   idle_pct;
  int   cycle_count;

  arct_item_if   item_if();
  arct_result_if result_if();

  window_tracker tracker = new();

  access_range_conflict_tracker u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Bound the run
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic access_item_t access(op_t op, logic [7:0] id, logic wr,
                                          logic [15:0] start, logic [15:0] len,
                                          logic [15:0] bsz);
    access_item_t it;
    it.op    = op;
    it.id    = id;
    it.wr    = wr;
    it.start = start;
    it.len   = len;
    it.bsz   = bsz;
    return it;
  endfunction

  // Mostly a small pool of owners so windows collide, sometimes zero or any id
  function automatic logic [7:0] pick_id();
    int p;
    p = $urandom_range(0, 99);
    if (p < 5) return 8'd0;
    if (p < 15) return 8'($urandom_range(1, 255));
    return 8'($urandom_range(1, 6));
  endfunction

  // Drive one beat on the item channel and hold it until taken
  task automatic send_item(access_item_t it);
    int gap;
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      item_if.valid <= 1'b0;
      gap = $urandom_range(1, 14);
      repeat (gap) @(posedge clk);
    end
    item_if.valid        <= 1'b1;
    item_if.op           <= it.op;
    item_if.requester_id <= it.id;
    item_if.is_write     <= it.wr;
    item_if.start_offset <= it.start;
    item_if.length       <= it.len;
    item_if.buffer_size  <= it.bsz;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    tracker.note_item(it);
  endtask

  // Hold off the sender until every predicted beat has come back
  task automatic drain();
    item_if.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_beats.size() != 0) @(posedge clk);
  endtask

  // Result side: take beats, stall in random bursts
  initial begin : result_sink
    res_t got;
    int   stall;
    stall = 0;
    result_if.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (result_if.valid && result_if.ready) begin
        got.kind          = kind_t'(result_if.kind);
        got.conflict_slot = result_if.conflict_slot;
        got.other_owner   = result_if.other_owner;
        got.status        = result_if.status;
        got.slot_granted  = result_if.slot_granted;
        got.last          = result_if.last;
        tracker.check_beat(got);
      end
      if (stall > 0) begin
        stall--;
        result_if.ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
        stall = $urandom_range(1, 14) - 1;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // Stimulus
  initial begin : stimulus
    access_item_t directed [$];
    access_item_t it;
    int           pick;
    rst                  = 1'b1;
    idle_pct             = 20;
    item_if.valid        = 1'b0;
    item_if.op           = OP_BEGIN;
    item_if.requester_id = '0;
    item_if.is_write     = 1'b0;
    item_if.start_offset = '0;
    item_if.length       = '0;
    item_if.buffer_size  = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed = '{
      access(OP_BEGIN,   8'd1,   1'b1, 16'h0000, 16'd1,    16'd1),
      // read over a write window
      access(OP_BEGIN,   8'd2,   1'b0, 16'h0000, 16'd4,    16'hFFFF),
      // write over both a write and a read window
      access(OP_BEGIN,   8'd3,   1'b1, 16'h0000, 16'hFFFF, 16'hFFFF),
      // window runs past the offset space and saturates
      access(OP_BEGIN,   8'd4,   1'b0, 16'hFFFF, 16'hFFFF, 16'h8000),
      access(OP_BEGIN,   8'd5,   1'b1, 16'hFFFF, 16'd1,    16'd1),
      // read over read is ignored
      access(OP_BEGIN,   8'd6,   1'b0, 16'h0002, 16'd1,    16'd7),
      // own window is skipped
      access(OP_BEGIN,   8'd1,   1'b1, 16'h0000, 16'd2,    16'd1),
      // zero length, then zero buffer size
      access(OP_BEGIN,   8'd7,   1'b1, 16'h1234, 16'd0,    16'd5),
      access(OP_BEGIN,   8'd7,   1'b1, 16'h1234, 16'd5,    16'd0),
      // requester zero sees every window, claims nothing
      access(OP_BEGIN,   8'd0,   1'b1, 16'h0000, 16'hFFFF, 16'hFFFF),
      access(OP_BEGIN,   8'd8,   1'b0, 16'h9000, 16'd16,   16'd16),
      // table full
      access(OP_BEGIN,   8'd9,   1'b1, 16'h9008, 16'd1,    16'd1),
      access(OP_RELEASE, 8'd0,   1'b0, 16'h0000, 16'd0,    16'd0),
      access(OP_RELEASE, 8'd3,   1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF),
      access(OP_BEGIN,   8'd9,   1'b1, 16'h9008, 16'd1,    16'd1),
      // owner with no windows
      access(OP_RELEASE, 8'd42,  1'b0, 16'h0000, 16'd0,    16'd0),
      access(OP_BEGIN,   8'd255, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF),
      access(OP_RELEASE, 8'd1,   1'b0, 16'h0000, 16'd0,    16'd0),
      access(OP_RELEASE, 8'd2,   1'b0, 16'h0000, 16'd0,    16'd0),
      access(OP_RELEASE, 8'd4,   1'b0, 16'h0000, 16'd0,    16'd0),
      access(OP_RELEASE, 8'd5,   1'b0, 16'h0000, 16'd0,    16'd0),
      access(OP_RELEASE, 8'd6,   1'b0, 16'h0000, 16'd0,    16'd0),
      access(OP_RELEASE, 8'd8,   1'b0, 16'h0000, 16'd0,    16'd0)
    };
    foreach (directed[i]) send_item(directed[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // vary idling in phases, none in the tail
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 10;
          default: idle_pct = 35;
        endcase
      end
      if (n == RANDOM_ITEMS / 3) drain();
      if (n >= RANDOM_ITEMS - QUIET_ITEMS) begin
        if (n == RANDOM_ITEMS - QUIET_ITEMS) drain();
        idle_pct = 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // clustered windows in a small region
        it = access(OP_BEGIN, pick_id(), 1'($urandom_range(0, 1)),
                    16'($urandom_range(0, 255)), 16'($urandom_range(1, 64)),
                    16'($urandom_range(1, 16'hFFFF)));
      end else if (pick < 80) begin
        it = access(OP_RELEASE, pick_id(), 1'($urandom_range(0, 1)),
                    16'($urandom), 16'($urandom), 16'($urandom));
      end else if (pick < 93) begin
        it = access(OP_BEGIN, pick_id(), 1'($urandom_range(0, 1)),
                    16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        // length and buffer size each either zero or random
        it = access(OP_BEGIN, pick_id(), 1'($urandom_range(0, 1)), 16'($urandom),
                    16'($urandom_range(0, 1) ? 0 : $urandom),
                    16'($urandom_range(0, 1) ? 0 : $urandom));
      end
      send_item(it);
    end

    drain();
    repeat (2 * NUM_SLOTS + 8) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
